// ===== rtl/core/fcpwm_pkg.sv =====
// shared constants and types for the four-channel pwm register block
package fcpwm_pkg;

  // channel count and counter width
  localparam int CHANNELS   = 4;
  localparam int COUNT_BITS = 17;
  localparam int DUTY_BITS  = COUNT_BITS + 1;
  localparam int CTRL_BITS  = 16;

  // register window layout
  localparam int ADDR_BITS  = 8;
  localparam int OFF_BITS   = 5;
  localparam int CH_BITS    = ADDR_BITS - OFF_BITS;
  localparam int DATA_BITS  = 32;
  localparam int READ_BITS  = 18;

  localparam logic [OFF_BITS-1:0] OFF_CTRL   = 5'h00;
  localparam logic [OFF_BITS-1:0] OFF_DUTY   = 5'h04;
  localparam logic [OFF_BITS-1:0] OFF_PERIOD = 5'h08;

  // configuration register reset
  localparam logic [CTRL_BITS-1:0] RUN_CODE_RST = 16'h6000;

  // request kinds carried on tuser
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  // configuration register indexes
  localparam logic [0:0] CFG_RUN_CODE = 1'b0;

endpackage

// ===== rtl/core/four_channel_pwm_registers_top.sv =====
// top level of the four-channel pwm timer with its register window
//
// Takes one transaction per clock: a tick, a register write or a register read.
// Every transaction yields exactly one result, offered on the result stream
// right after the accepting edge, carrying the read data and the four pwm
// levels after that transaction. All channel state updates in the same cycle
// the transaction is accepted, so the sustained rate is one transaction per
// cycle; the single output register only stalls the input while a finished
// result is held by out_tready low.
// The run code is set through the apb port at byte address 0.
module four_channel_pwm_registers_top
  import fcpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // address [7:0], write_data [39:8]
  input  logic [1:0]  in_tuser,   // req_type [1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // read_data [17:0], pwm_level [21:18], zero [23:22]
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // channel state
  logic [CTRL_BITS-1:0]  ctrl_r   [CHANNELS];
  logic [CTRL_BITS-1:0]  ctrl_nxt [CHANNELS];
  logic [DUTY_BITS-1:0]  duty_r   [CHANNELS];
  logic [DUTY_BITS-1:0]  duty_nxt [CHANNELS];
  logic [COUNT_BITS-1:0] per_r    [CHANNELS];
  logic [COUNT_BITS-1:0] per_nxt  [CHANNELS];
  logic [COUNT_BITS-1:0] cnt_r    [CHANNELS];
  logic [COUNT_BITS-1:0] cnt_nxt  [CHANNELS];

  logic [CTRL_BITS-1:0]  run_code_r;
  logic                  out_valid_r;
  logic [READ_BITS-1:0]  rdata_r;
  logic [READ_BITS-1:0]  rdata_nxt;
  logic [CHANNELS-1:0]   level_r;
  logic [CHANNELS-1:0]   level_nxt;

  // unpacked request fields
  logic [1:0]            req;
  logic [ADDR_BITS-1:0]  addr;
  logic [DATA_BITS-1:0]  wdata;
  logic [CH_BITS-1:0]    ch;
  logic [OFF_BITS-1:0]   off;
  logic                  in_fire;
  logic                  cfg_wr;

  assign req     = in_tuser;
  assign addr    = in_tdata[ADDR_BITS-1:0];
  assign wdata   = in_tdata[ADDR_BITS +: DATA_BITS];
  assign ch      = addr[ADDR_BITS-1 -: CH_BITS];
  assign off     = addr[OFF_BITS-1:0];

  // output register frees the input when empty or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // apb configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == CFG_RUN_CODE) ? {16'd0, run_code_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_code_r <= RUN_CODE_RST;
    end else if (cfg_wr && cfg_paddr[2] == CFG_RUN_CODE) begin
      run_code_r <= cfg_pwdata[CTRL_BITS-1:0];
    end
  end

  // per-channel next state, read mux and levels
  always_comb begin
    logic                  hit;
    logic                  run_pre;
    logic                  run_post;
    logic [COUNT_BITS:0]   inc;
    rdata_nxt = '0;
    level_nxt = '0;
    for (int n = 0; n < CHANNELS; n++) begin
      hit         = (ch == CH_BITS'(n));
      ctrl_nxt[n] = ctrl_r[n];
      duty_nxt[n] = duty_r[n];
      per_nxt[n]  = per_r[n];
      cnt_nxt[n]  = cnt_r[n];
      run_pre     = (ctrl_r[n] == run_code_r) && (per_r[n] != '0);
      inc         = {1'b0, cnt_r[n]} + 1'b1;
      case (req)
        REQ_TICK: begin
          if (run_pre) begin
            cnt_nxt[n] = (inc >= {1'b0, per_r[n]}) ? '0 : inc[COUNT_BITS-1:0];
          end
        end
        REQ_WRITE: begin
          if (hit) begin
            if (off == OFF_CTRL)   ctrl_nxt[n] = wdata[CTRL_BITS-1:0];
            if (off == OFF_DUTY)   duty_nxt[n] = wdata[DUTY_BITS-1:0];
            if (off == OFF_PERIOD) per_nxt[n]  = wdata[COUNT_BITS-1:0];
          end
        end
        REQ_READ: begin
          if (hit) begin
            if (off == OFF_CTRL)   rdata_nxt = READ_BITS'(ctrl_r[n]);
            if (off == OFF_DUTY)   rdata_nxt = READ_BITS'(duty_r[n]);
            if (off == OFF_PERIOD) rdata_nxt = READ_BITS'(per_r[n]);
          end
        end
        default: begin
        end
      endcase
      // stopped or zero-period channel holds its counter at zero
      run_post = (ctrl_nxt[n] == run_code_r) && (per_nxt[n] != '0);
      if (!run_post) cnt_nxt[n] = '0;
      level_nxt[n] = run_post &&
                     (duty_nxt[n][COUNT_BITS] || (cnt_nxt[n] < duty_nxt[n][COUNT_BITS-1:0]));
    end
  end

  // channel state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < CHANNELS; n++) begin
        ctrl_r[n] <= '0;
        duty_r[n] <= '0;
        per_r[n]  <= '0;
        cnt_r[n]  <= '0;
      end
    end else if (in_fire) begin
      for (int n = 0; n < CHANNELS; n++) begin
        ctrl_r[n] <= ctrl_nxt[n];
        duty_r[n] <= duty_nxt[n];
        per_r[n]  <= per_nxt[n];
        cnt_r[n]  <= cnt_nxt[n];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rdata_r <= rdata_nxt;
      level_r <= level_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, level_r, rdata_r};

  // a transaction leaves every stopped channel with a zero counter
  for (genvar g = 0; g < CHANNELS; g++) begin : g_chk
    a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
      in_fire |=> ((ctrl_r[g] == run_code_r) && (per_r[g] != '0)) || cnt_r[g] == '0)
      else $error("stopped channel counter not zero");
  end

  // only read transactions return nonzero read data
  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && req != REQ_READ) |=> rdata_r == '0)
    else $error("nonzero read data on non-read transaction");

  // every accepted transaction leaves a result pending
  a_result_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted transaction produced no result");

endmodule
